// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the block.
package i2cm_pkg;

    // Queue depths (defaults for the top-level parameters)
    localparam int I2CM_CMD_Q_DEPTH = 2;
    localparam int I2CM_RES_Q_DEPTH = 2;

    // Raw command kinds on the input beat
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Decoded operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Register indexes
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_release;
        logic       ready_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_out_item;

    // Classified tick as held in the command queue
    typedef struct packed {
        logic       active;
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       we;
        logic       idx;
        logic [7:0] data;
    } t_cfg_wr;

endpackage

// ===== rtl/i2cm_fifo.sv =====
// Small register FIFO, generic over depth and payload type.
// Uses i2cm_pkg only for a common import; used by front end and top level.
module i2cm_fifo
    import i2cm_pkg::*;
#(
    parameter int  DEPTH = I2CM_CMD_Q_DEPTH,
    parameter type t_data = t_cmd
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_en,
    input  t_data i_wr_data,
    output logic  o_full,
    input  logic  i_rd_en,
    output t_data o_rd_data,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_data            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr_en && !o_full;
    assign w_rd      = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== rtl/i2cm_front.sv =====
// Front end: decodes each input tick into an operation and queues it.
// Depends on i2cm_pkg and i2cm_fifo.
module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int Q_DEPTH = I2CM_CMD_Q_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_take,
    output t_cmd     o_cmd,
    output logic     o_valid
);

    t_cmd w_cmd;
    logic w_empty;

    // unknown kinds become inactive ticks
    always_comb begin
        w_cmd.active      = 1'b1;
        w_cmd.op          = OP_START;
        w_cmd.tx_byte     = i_item.tx_byte;
        w_cmd.ack_to_send = i_item.ack_to_send;
        w_cmd.sda_in      = i_item.sda_in;
        case (i_item.kind)
            KIND_START: w_cmd.op = OP_START;
            KIND_STOP:  w_cmd.op = OP_STOP;
            KIND_WRITE: w_cmd.op = OP_WRITE;
            KIND_READ:  w_cmd.op = OP_READ;
            default:    w_cmd.active = 1'b0;
        endcase
    end

    i2cm_fifo #(
        .DEPTH  (Q_DEPTH),
        .t_data (t_cmd)
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_push),
        .i_wr_data (w_cmd),
        .o_full    (o_full),
        .i_rd_en   (i_take),
        .o_rd_data (o_cmd),
        .o_empty   (w_empty)
    );

    assign o_valid = !w_empty;

endmodule

// ===== rtl/i2cm_engine.sv =====
// Back end: bus phase sequencer, one tick per queued beat, plus config registers.
// Depends on i2cm_pkg.
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    input  logic      i_out_full,
    output logic      o_step,
    output t_out_item o_item
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_WR_LOW  = 4'd5;
    localparam logic [3:0] PH_WR_HIGH = 4'd6;
    localparam logic [3:0] PH_WR_TAIL = 4'd7;
    localparam logic [3:0] PH_WA_REL  = 4'd8;
    localparam logic [3:0] PH_WA_HIGH = 4'd9;
    localparam logic [3:0] PH_WA_POLL = 4'd10;
    localparam logic [3:0] PH_RD_LOW  = 4'd11;
    localparam logic [3:0] PH_RD_HIGH = 4'd12;
    localparam logic [3:0] PH_RA_LOW  = 4'd13;
    localparam logic [3:0] PH_RA_HIGH = 4'd14;

    logic [7:0] r_half_period, r_ack_timeout;
    logic [3:0] r_phase, n_phase;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_delay, n_delay;
    logic [7:0] r_wait, n_wait;
    logic       r_pending, n_pending;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_rx, n_rx;
    logic       r_fail, n_fail;
    logic       n_done;
    logic [7:0] w_hp;

    assign o_step = i_cmd_valid && !i_out_full;
    assign w_hp   = (r_half_period == 8'd0) ? 8'd1 : r_half_period;

    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_delay   = r_delay;
        n_wait    = r_wait;
        n_pending = r_pending;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_rx      = r_rx;
        n_fail    = r_fail;
        n_done    = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_cmd.active) begin
                n_fail  = 1'b0;
                n_delay = w_hp;
                case (i_cmd.op)
                    OP_START: begin
                        n_phase = PH_ST_A;
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                    end
                    OP_STOP: begin
                        n_phase = PH_SP_A;
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                    end
                    OP_WRITE: begin
                        n_shift = i_cmd.tx_byte;
                        n_bit   = 4'd0;
                        n_phase = PH_WR_LOW;
                        n_scl   = 1'b0;
                        n_sda   = i_cmd.tx_byte[7];
                    end
                    default: begin
                        n_shift   = 8'd0;
                        n_bit     = 4'd0;
                        n_pending = i_cmd.ack_to_send;
                        n_phase   = PH_RD_LOW;
                        n_scl     = 1'b0;
                        n_sda     = 1'b1;
                    end
                endcase
            end
        end else if (r_phase == PH_WA_POLL) begin
            if (!i_cmd.sda_in) begin
                n_scl   = 1'b0;
                n_phase = PH_IDLE;
                n_done  = 1'b1;
            end else if (r_wait >= r_ack_timeout) begin
                n_fail  = 1'b1;
                n_phase = PH_SP_A;
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_delay = w_hp;
            end else begin
                n_wait = r_wait + 8'd1;
            end
        end else if (r_delay > 8'd1) begin
            n_delay = r_delay - 8'd1;
        end else begin
            n_delay = w_hp;
            case (r_phase)
                PH_ST_A: begin
                    n_phase = PH_ST_B;
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                end
                PH_ST_B: begin
                    n_delay = r_delay;
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                PH_SP_A: begin
                    n_phase = PH_SP_B;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                PH_SP_B: begin
                    n_delay = r_delay;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                PH_WR_LOW: begin
                    n_phase = PH_WR_HIGH;
                    n_scl   = 1'b1;
                end
                PH_WR_HIGH: begin
                    n_phase = PH_WR_TAIL;
                    n_scl   = 1'b0;
                end
                PH_WR_TAIL: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = r_bit + 4'd1;
                    n_scl   = 1'b0;
                    if (n_bit >= 4'd8) begin
                        n_phase = PH_WA_REL;
                        n_sda   = 1'b1;
                    end else begin
                        n_phase = PH_WR_LOW;
                        n_sda   = r_shift[6];
                    end
                end
                PH_WA_REL: begin
                    n_phase = PH_WA_HIGH;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                PH_WA_HIGH: begin
                    n_delay = r_delay;
                    n_wait  = 8'd0;
                    n_phase = PH_WA_POLL;
                end
                PH_RD_LOW: begin
                    n_phase = PH_RD_HIGH;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                PH_RD_HIGH: begin
                    // sample on the last tick of SCL high
                    n_shift = {r_shift[6:0], i_cmd.sda_in};
                    n_bit   = r_bit + 4'd1;
                    n_scl   = 1'b0;
                    if (n_bit >= 4'd8) begin
                        n_phase = PH_RA_LOW;
                        n_sda   = !r_pending;
                    end else begin
                        n_phase = PH_RD_LOW;
                        n_sda   = 1'b1;
                    end
                end
                PH_RA_LOW: begin
                    n_phase = PH_RA_HIGH;
                    n_scl   = 1'b1;
                end
                PH_RA_HIGH: begin
                    n_delay = r_delay;
                    n_scl   = 1'b0;
                    n_sda   = 1'b1;
                    n_rx    = r_shift;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                default: begin
                    n_delay = r_delay;
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_item.scl_out     = n_scl;
        o_item.sda_release = n_sda;
        o_item.ready_res   = (n_phase == PH_IDLE);
        o_item.done_res    = n_done;
        o_item.rx_byte     = n_rx;
        o_item.ack_failed  = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= 8'd2;
            r_ack_timeout <= 8'd250;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                REG_HALF_PERIOD: r_half_period <= i_cfg.data;
                REG_ACK_TIMEOUT: r_ack_timeout <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit     <= 4'd0;
            r_shift   <= 8'd0;
            r_delay   <= 8'd0;
            r_wait    <= 8'd0;
            r_pending <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_rx      <= 8'd0;
            r_fail    <= 1'b0;
        end else if (o_step) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_delay   <= n_delay;
            r_wait    <= n_wait;
            r_pending <= n_pending;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_rx      <= n_rx;
            r_fail    <= n_fail;
        end
    end

endmodule

// ===== rtl/i2c_master_bit_engine_unit.sv =====
// Top level of the I2C master bit engine: front end, sequencer, result queue.
// Depends on i2cm_pkg, i2cm_fifo, i2cm_front and i2cm_engine.
//
// Each input beat is one bus tick: an optional command (start, stop, write
// byte, read byte) plus the sampled SDA level; every beat yields exactly one
// result beat with SCL, SDA release, ready, done, the last received byte and
// the ack-failure flag. Throughput is one beat per clock while beats are queued and
// the result queue is not full; the sequencer advances its phase, delay and shift
// registers once per beat, and that update sets the rate. A pushed beat is
// registered in the command queue, then in the result queue when the sequencer
// steps. Both queues are Q_DEPTH / OUT_DEPTH entries deep, so a stalled
// consumer back-pressures push through full only once both are filled.
// Config writes are taken whenever the write enable is high and should be
// issued only while no beats are in flight.
module i2c_master_bit_engine_unit
    import i2cm_pkg::*;
#(
    parameter int Q_DEPTH   = I2CM_CMD_Q_DEPTH,
    parameter int OUT_DEPTH = I2CM_RES_Q_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam int FLIGHT_W = $clog2(Q_DEPTH + OUT_DEPTH + 1);

    t_cmd      w_cmd;
    logic      w_cmd_valid;
    logic      w_step;
    logic      w_out_full;
    t_out_item w_eng_item;
    t_cfg_wr   w_cfg;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    // front: classify and buffer incoming ticks
    i2cm_front #(
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .i_take  (w_step),
        .o_cmd   (w_cmd),
        .o_valid (w_cmd_valid)
    );

    // back: one bus tick per beat, stalls only on a full result queue
    i2cm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .i_out_full  (w_out_full),
        .o_step      (w_step),
        .o_item      (w_eng_item)
    );

    // result queue decouples the sequencer from the consumer
    i2cm_fifo #(
        .DEPTH  (OUT_DEPTH),
        .t_data (t_out_item)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_step),
        .i_wr_data (w_eng_item),
        .o_full    (w_out_full),
        .i_rd_en   (pop),
        .o_rd_data (o_out_item),
        .o_empty   (empty)
    );

    // beats in flight, for checking only
    logic [FLIGHT_W-1:0] r_flight;
    logic                w_in_acc, w_out_acc;

    assign w_in_acc  = push && !full;
    assign w_out_acc = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flight <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_flight <= r_flight + 1'b1;
        end else if (w_out_acc && !w_in_acc) begin
            r_flight <= r_flight - 1'b1;
        end
    end

    // the two queues together bound the beats held
    a_flight_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flight <= FLIGHT_W'(Q_DEPTH + OUT_DEPTH))
        else $error("more beats in flight than queue space");

    // a finishing command always leaves the engine idle
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_eng_item.done_res |-> w_eng_item.ready_res)
        else $error("done without returning to idle");

    // an empty result queue with no queued command means every accepted beat has been delivered
    a_empty_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty && !w_cmd_valid |-> r_flight == '0)
        else $error("beat lost between queues");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

// ===== tb/i2cm_bus_checker.sv =====
`timescale 1ns / 1ps
// Checker for the I2C master bit engine: watches the push, pop and register ports.
// It predicts every result beat and compares it. Depends on i2cm_pkg.
module i2cm_bus_checker
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  t_in_item   i_in_item,
    input  logic       i_empty,
    input  logic       i_pop,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending,
    output logic       o_eng_idle
);

    typedef enum logic [3:0] {
        S_IDLE, S_ST_A, S_ST_B, S_SP_A, S_SP_B, S_WR_LOW, S_WR_HIGH, S_WR_TAIL,
        S_WA_REL, S_WA_HIGH, S_WA_POLL, S_RD_LOW, S_RD_HIGH, S_RA_LOW, S_RA_HIGH
    } t_eng_state;

    logic [7:0] cfg_half;
    logic [7:0] cfg_tmo;

    t_eng_state eng_st;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [7:0] dly;
    logic [7:0] poll_cnt;
    logic       ack_pend;
    logic       scl_q;
    logic       sda_q;
    logic [7:0] rx_last;
    logic       fail_q;

    t_out_item  bus_levels_q[$];
    int         errs;

    // load a timed state; a zero half period counts as one tick
    function automatic void goto_state(input t_eng_state st, input logic scl,
                                       input logic sda);
        eng_st = st;
        scl_q  = scl;
        sda_q  = sda;
        dly    = (cfg_half != 8'd0) ? cfg_half : 8'd1;
    endfunction

    function automatic t_out_item advance_bus_tick(input t_in_item b);
        t_out_item r;
        logic      fin;
        fin = 1'b0;
        if (eng_st == S_IDLE) begin
            if (b.kind >= KIND_START && b.kind <= KIND_READ)
                fail_q = 1'b0;
            case (b.kind)
                KIND_START: goto_state(S_ST_A, 1'b1, 1'b1);
                KIND_STOP:  goto_state(S_SP_A, 1'b0, 1'b0);
                KIND_WRITE: begin
                    shreg   = b.tx_byte;
                    bit_cnt = 4'd0;
                    goto_state(S_WR_LOW, 1'b0, b.tx_byte[7]);
                end
                KIND_READ: begin
                    shreg    = 8'd0;
                    bit_cnt  = 4'd0;
                    ack_pend = b.ack_to_send;
                    goto_state(S_RD_LOW, 1'b0, 1'b1);
                end
                default: ;
            endcase
        end else if (eng_st == S_WA_POLL) begin
            if (!b.sda_in) begin
                scl_q  = 1'b0;
                eng_st = S_IDLE;
                fin    = 1'b1;
            end else if (poll_cnt >= cfg_tmo) begin
                fail_q = 1'b1;
                goto_state(S_SP_A, 1'b0, 1'b0);
            end else begin
                poll_cnt = poll_cnt + 8'd1;
            end
        end else if (dly > 8'd1) begin
            dly = dly - 8'd1;
        end else begin
            case (eng_st)
                S_ST_A:    goto_state(S_ST_B, 1'b1, 1'b0);
                S_ST_B: begin
                    scl_q  = 1'b0;
                    eng_st = S_IDLE;
                    fin    = 1'b1;
                end
                S_SP_A:    goto_state(S_SP_B, 1'b1, 1'b1);
                S_SP_B: begin
                    eng_st = S_IDLE;
                    fin    = 1'b1;
                end
                S_WR_LOW:  goto_state(S_WR_HIGH, 1'b1, sda_q);
                S_WR_HIGH: goto_state(S_WR_TAIL, 1'b0, sda_q);
                S_WR_TAIL: begin
                    shreg   = shreg << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                        goto_state(S_WA_REL, 1'b0, 1'b1);
                    else
                        goto_state(S_WR_LOW, 1'b0, shreg[7]);
                end
                S_WA_REL:  goto_state(S_WA_HIGH, 1'b1, 1'b1);
                S_WA_HIGH: begin
                    poll_cnt = 8'd0;
                    eng_st   = S_WA_POLL;
                end
                S_RD_LOW:  goto_state(S_RD_HIGH, 1'b1, 1'b1);
                S_RD_HIGH: begin
                    shreg   = {shreg[6:0], b.sda_in};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                        goto_state(S_RA_LOW, 1'b0, !ack_pend);
                    else
                        goto_state(S_RD_LOW, 1'b0, 1'b1);
                end
                S_RA_LOW:  goto_state(S_RA_HIGH, 1'b1, sda_q);
                S_RA_HIGH: begin
                    scl_q   = 1'b0;
                    sda_q   = 1'b1;
                    rx_last = shreg;
                    eng_st  = S_IDLE;
                    fin     = 1'b1;
                end
                default:   eng_st = S_IDLE;
            endcase
        end
        r.scl_out     = scl_q;
        r.sda_release = sda_q;
        r.ready_res   = (eng_st == S_IDLE);
        r.done_res    = fin;
        r.rx_byte     = rx_last;
        r.ack_failed  = fail_q;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            cfg_half = 8'd2;
            cfg_tmo  = 8'd250;
            eng_st   = S_IDLE;
            bit_cnt  = 4'd0;
            shreg    = 8'd0;
            dly      = 8'd0;
            poll_cnt = 8'd0;
            ack_pend = 1'b0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            rx_last  = 8'd0;
            fail_q   = 1'b0;
            errs     = 0;
            bus_levels_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_HALF_PERIOD)
                    cfg_half = i_cfg_data;
                else
                    cfg_tmo = i_cfg_data;
            end
            if (i_pop && !i_empty) begin
                if (bus_levels_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result beat with nothing expected", $realtime);
                end else begin
                    want = bus_levels_q.pop_front();
                    if (want !== i_out_item) begin
                        errs++;
                        if (errs <= 10) begin
                            $write("%0t: mismatch exp/act scl %b/%b sda %b/%b ",
                                   $realtime, want.scl_out, i_out_item.scl_out,
                                   want.sda_release, i_out_item.sda_release);
                            $display("ready %b/%b done %b/%b rx %h/%h fail %b/%b",
                                     want.ready_res, i_out_item.ready_res,
                                     want.done_res, i_out_item.done_res,
                                     want.rx_byte, i_out_item.rx_byte,
                                     want.ack_failed, i_out_item.ack_failed);
                        end
                    end
                end
            end
            if (i_push && !i_full)
                bus_levels_q.push_back(advance_bus_tick(i_in_item));
        end
        o_errors   <= errs;
        o_pending  <= bus_levels_q.size();
        o_eng_idle <= (eng_st == S_IDLE);
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the I2C master bit engine testbench: clock, reset, stimulus and verdict.
// Depends on i2cm_pkg, i2c_master_bit_engine_unit and i2cm_bus_checker.
module tb_top;
    import i2cm_pkg::*;

    // kinds the engine must ignore
    localparam logic [2:0] KIND_RSVD_A = 3'd5;
    localparam logic [2:0] KIND_RSVD_B = 3'd6;
    localparam logic [2:0] KIND_RSVD_C = 3'd7;

    // how sda_in behaves over the ticks of one command
    localparam int SDA_LOW      = 0;  // slave acks at once, reads give zeros
    localparam int SDA_HIGH     = 1;  // no ack, so the timeout and stop fire
    localparam int SDA_RARE_LOW = 2;  // ack after a few polls, or timeout
    localparam int SDA_COIN     = 3;  // fair coin each tick

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_in_item   in_beat;
    logic       empty;
    logic       pop;
    t_out_item  out_beat;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    int         fail_cnt;
    int         lvl_pending;
    logic       eng_idle;
    logic       steady;     // while set neither side idles
    int         cmds_sent;  // real commands issued (start, stop, write, read)

    i2c_master_bit_engine_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_beat),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    i2cm_bus_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_in_item  (in_beat),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_out_item (out_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (fail_cnt),
        .o_pending  (lvl_pending),
        .o_eng_idle (eng_idle)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: pop held low about 37% of cycles, never inside the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= steady || ($urandom_range(0, 99) >= 37);
    end

    // Watchdog. A full run is roughly a thousand beats, with both sides idling at
    // times; this allows over ten times that.
    initial begin
        #500us;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic pick_sda(input int mode);
        case (mode)
            SDA_LOW:      return 1'b0;
            SDA_HIGH:     return 1'b1;
            SDA_RARE_LOW: return ($urandom_range(0, 7) != 0);
            default:      return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // kind carried by the beat right after a command, when the engine is busy
    function automatic logic [2:0] busy_kind();
        return ($urandom_range(0, 1) == 0) ? KIND_NONE : 3'($urandom_range(0, 7));
    endfunction

    // mostly acked, sometimes late or never
    function automatic int pick_ack_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return SDA_LOW;
        else if (r < 85)
            return SDA_RARE_LOW;
        else
            return SDA_HIGH;
    endfunction

    // One input beat. Outside the steady stretch, idle gaps are geometric so about 37% of cycles idle.
    // idle_seen is the predicted engine state before this beat took effect.
    task automatic send_beat(input t_in_item b, output logic idle_seen);
        while (!steady && $urandom_range(0, 99) < 37) begin
            push    <= 1'b0;
            in_beat <= $bits(t_in_item)'($urandom);
            @(posedge i_clk);
        end
        push    <= 1'b1;
        in_beat <= b;
        do
            @(posedge i_clk);
        while (full);
        idle_seen = eng_idle;
    endtask

    // Issue one command, then tick the engine until it is idle again. The first
    // following beat may carry another command, which a busy engine drops.
    task automatic run_cmd(input logic [2:0] k, input logic [7:0] tx, input logic ackv,
                           input int mode, input logic [2:0] follow);
        logic       idle_seen;
        logic [2:0] fk;
        send_beat({k, tx, ackv, pick_sda(mode)}, idle_seen);
        if (k >= KIND_START && k <= KIND_READ) begin
            cmds_sent++;
            fk = follow;
        end else begin
            fk = KIND_NONE;
        end
        do begin
            send_beat({fk, 8'($urandom), 1'($urandom), pick_sda(mode)}, idle_seen);
            fk = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(KIND_RSVD_A, KIND_RSVD_C))
                                             : KIND_NONE;
        end while (!idle_seen);
    endtask

    // Registers are only touched with nothing in flight and the engine idle.
    task automatic load_regs(input logic [7:0] hp, input logic [7:0] tmo);
        push <= 1'b0;
        @(posedge i_clk);
        while (lvl_pending != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_HALF_PERIOD;
        i_cfg_data <= hp;
        @(posedge i_clk);
        i_cfg_idx  <= REG_ACK_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // A well-formed bus transfer: start, address, a few data bytes, stop.
    task automatic run_transfer();
        int   nbytes;
        logic rd;
        nbytes = $urandom_range(1, 4);
        rd     = 1'($urandom_range(0, 1));
        run_cmd(KIND_START, 8'($urandom), 1'($urandom), SDA_COIN, busy_kind());
        run_cmd(KIND_WRITE, {7'($urandom), rd}, 1'($urandom), pick_ack_mode(),
                busy_kind());
        for (int i = 0; i < nbytes; i++) begin
            if (rd)
                run_cmd(KIND_READ, 8'($urandom), (i != nbytes - 1), SDA_COIN, busy_kind());
            else
                run_cmd(KIND_WRITE, 8'($urandom), 1'($urandom), pick_ack_mode(),
                        busy_kind());
        end
        run_cmd(KIND_STOP, 8'($urandom), 1'($urandom), SDA_COIN, busy_kind());
    endtask

    // One register setting; about one pick in five is a single random command instead of a transfer.
    task automatic run_phase(input logic [7:0] hp, input logic [7:0] tmo, input int n_cmds,
                             input logic no_idle);
        int stop_at;
        load_regs(hp, tmo);
        steady  <= no_idle;
        stop_at = cmds_sent + n_cmds;
        while (cmds_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0)
                run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                        $urandom_range(SDA_LOW, SDA_COIN), busy_kind());
            else
                run_transfer();
        end
        steady <= 1'b0;
    endtask

    initial begin
        push       = 1'b0;
        in_beat    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_HALF_PERIOD;
        i_cfg_data = 8'd0;
        i_rst_n    = 1'b0;
        steady     = 1'b0;
        cmds_sent  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, at the reset register values: ignored kinds on an idle
        // engine, every command, byte extremes, ack and no-ack, commands
        // dropped while busy, and the failure flag surviving an ignored kind.
        run_cmd(KIND_RSVD_A, 8'hFF, 1'b1, SDA_COIN, KIND_NONE);
        run_cmd(KIND_RSVD_B, 8'h00, 1'b0, SDA_COIN, KIND_NONE);
        run_cmd(KIND_RSVD_C, 8'hFF, 1'b0, SDA_COIN, KIND_NONE);
        run_cmd(KIND_NONE, 8'hFF, 1'b1, SDA_HIGH, KIND_NONE);
        run_cmd(KIND_STOP, 8'h00, 1'b0, SDA_HIGH, KIND_START);
        run_cmd(KIND_START, 8'hFF, 1'b1, SDA_COIN, KIND_WRITE);
        run_cmd(KIND_WRITE, 8'hFF, 1'b0, SDA_LOW, KIND_READ);
        run_cmd(KIND_WRITE, 8'h00, 1'b1, SDA_HIGH, KIND_STOP);
        run_cmd(KIND_RSVD_C, 8'h00, 1'b1, SDA_COIN, KIND_NONE);
        run_cmd(KIND_START, 8'h00, 1'b0, SDA_COIN, KIND_RSVD_A);
        run_cmd(KIND_WRITE, 8'hA5, 1'b0, SDA_RARE_LOW, KIND_NONE);
        run_cmd(KIND_READ, 8'h5A, 1'b1, SDA_COIN, KIND_WRITE);
        run_cmd(KIND_READ, 8'hFF, 1'b1, SDA_HIGH, KIND_READ);
        run_cmd(KIND_READ, 8'h00, 1'b0, SDA_LOW, KIND_NONE);
        run_cmd(KIND_STOP, 8'hFF, 1'b0, SDA_COIN, KIND_RSVD_B);

        // Random transfers at short settings: a steady stretch with the
        // shorter of the two timeouts, then a zero half period, which behaves as one.
        run_phase(8'd1,   8'd1,     3, 1'b1);
        run_phase(8'd0,   8'd2,     2, 1'b0);

        // drain, then let the pipeline settle before the verdict
        push <= 1'b0;
        @(posedge i_clk);
        while (lvl_pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0 && lvl_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
